>>> hdl/stg_pkg.sv
package stg_pkg;

    // Sample format codes held in the sample_format register
    typedef enum logic [1:0] {
        FMT_PCM16   = 2'd0,
        FMT_PCM32   = 2'd1,
        FMT_FLOAT   = 2'd2,
        FMT_SILENCE = 2'd3
    } fmt_t;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_PHASE_STEP    = 2'd0,
        REG_AMPLITUDE     = 2'd1,
        REG_SAMPLE_FORMAT = 2'd2,
        REG_CHANNEL_COUNT = 2'd3
    } reg_idx_t;

    // Live configuration, shared by front and back
    typedef struct packed {
        logic [31:0] phase_step;
        logic [15:0] amplitude;
        fmt_t        sample_format;
        logic [3:0]  channel_count;
    } cfg_t;

    localparam logic [31:0] PHASE_STEP_RST    = 32'd1700091221;
    localparam logic [15:0] AMPLITUDE_RST     = 16'd197;
    localparam fmt_t        SAMPLE_FORMAT_RST = FMT_FLOAT;
    localparam logic [3:0]  CHANNEL_COUNT_RST = 4'd2;

    localparam int SINE_W      = 15;   // table entries are 0..32767
    localparam int MAG_W       = 31;   // entry * amplitude, Q31
    localparam int QUEUE_DEPTH = 4;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // One quarter-wave table entry: Q30 Taylor series of sin up to x^13,
    // evaluated at the centre of the table cell. Elaboration only.
    function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned idx,
                                                       input int unsigned addr_bits);
        logic [63:0]        i;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        r;
        i    = 64'(idx);
        x    = (PI_Q30 * (64'd2 * i + 64'd1)) >> (addr_bits + 2);
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        if (sum < 0) begin
            sum = 64'sd0;
        end
        r = ($unsigned(sum) * 64'd32768 + (64'd1 << 29)) >> 30;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return SINE_W'(r);
    endfunction

endpackage

>>> hdl/stg_front.sv
module stg_front #(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  stg_pkg::cfg_t              cfg,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_eop,
    input  logic                       q_full,
    output logic                       q_push,
    output logic [TABLE_ADDR_BITS-1:0] q_idx,
    output logic                       q_neg,
    output logic                       q_eop
);
    import stg_pkg::*;

    logic [PHASE_BITS-1:0]      phase_reg;
    logic [PHASE_BITS-1:0]      phase_next;
    logic [1:0]                 quad;
    logic [TABLE_ADDR_BITS-1:0] raw_idx;
    logic                       s_xfer;

    assign s_ready = !q_full;
    assign s_xfer  = s_valid && s_ready;

    // Quadrant and mirrored table index from the current phase
    assign quad    = phase_reg[PHASE_BITS-1 -: 2];
    assign raw_idx = phase_reg[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    assign q_idx   = quad[0] ? ~raw_idx : raw_idx;
    assign q_neg   = quad[1];
    assign q_eop   = s_eop;

    // A frame with no channels only advances the phase
    assign q_push  = s_xfer && (cfg.channel_count != 4'd0);

    // Phase accumulator, wraps modulo 2^PHASE_BITS
    always_comb begin
        phase_next = phase_reg;
        if (s_xfer) begin
            phase_next = phase_reg + PHASE_BITS'(cfg.phase_step);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else begin
            phase_reg <= phase_next;
        end
    end

endmodule

>>> hdl/stg_queue.sv
module stg_queue #(
    parameter int DATA_W = 12,
    parameter int DEPTH  = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop_valid && pop_ready;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hdl/stg_synth.sv
module stg_synth #(
    parameter int TABLE_ADDR_BITS = 10
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  stg_pkg::cfg_t              cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [TABLE_ADDR_BITS-1:0] in_idx,
    input  logic                       in_neg,
    input  logic                       in_eop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [31:0]                out_word,
    output logic                       out_eop
);
    import stg_pkg::*;

    localparam int DEPTH = 1 << TABLE_ADDR_BITS;

    typedef logic [SINE_W-1:0] rom_t [DEPTH];

    function automatic rom_t build_rom();
        rom_t t;
        for (int i = 0; i < DEPTH; i++) begin
            t[i] = quarter_sine(i, TABLE_ADDR_BITS);
        end
        return t;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // Stage valids
    logic v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next, v4_reg, v4_next;
    logic ld1, ld2, ld3, ld4;

    // Stage 1: table read
    logic [SINE_W-1:0] sine1_reg;
    logic              neg1_reg, eop1_reg;
    // Stage 2: amplitude scaling
    logic [MAG_W-1:0]  mag2_reg;
    logic              neg2_reg, eop2_reg;
    // Stage 3: PCM magnitudes and leading-one position
    logic [MAG_W-1:0]  mag3_reg;
    logic [14:0]       m16_reg;
    logic [MAG_W-1:0]  m32_reg;
    logic [4:0]        lead3_reg;
    logic              neg3_reg, eop3_reg;
    // Stage 4: final word
    logic [31:0]       word4_reg;
    logic              eop4_reg;

    logic [45:0]       prod16;
    logic [14:0]       m16_next;
    logic [MAG_W-1:0]  m32_next;
    logic [4:0]        lead_next;
    logic [MAG_W-1:0]  norm;
    logic [23:0]       mant24;
    logic [6:0]        round_bits;
    logic              round_up;
    logic [24:0]       mant_r;
    logic [7:0]        expo;
    logic [22:0]       frac;
    logic [31:0]       float_word;
    logic [31:0]       pcm16_ext;
    logic [31:0]       pcm32_ext;
    logic [31:0]       word_next;

    // Stall chain: a stage loads when empty or when the next one moves
    assign ld4      = !v4_reg || out_ready;
    assign ld3      = !v3_reg || ld4;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign in_ready = ld1;

    assign v1_next = ld1 ? in_valid : v1_reg;
    assign v2_next = ld2 ? v1_reg : v2_reg;
    assign v3_next = ld3 ? v2_reg : v3_reg;
    assign v4_next = ld4 ? v3_reg : v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // Stage 1: registered table read
    always_ff @(posedge aclk) begin
        if (ld1) begin
            sine1_reg <= SINE_ROM[in_idx];
            neg1_reg  <= in_neg;
            eop1_reg  <= in_eop;
        end
    end

    // Stage 2: magnitude in Q31
    always_ff @(posedge aclk) begin
        if (ld2) begin
            mag2_reg <= MAG_W'(sine1_reg) * MAG_W'(cfg.amplitude);
            neg2_reg <= neg1_reg;
            eop2_reg <= eop1_reg;
        end
    end

    // Stage 3 logic: (mag * 32767) >> 31 by shift and subtract,
    // (mag * (2^31 - 1)) >> 31 is mag - 1 for any non-zero mag
    always_comb begin
        prod16    = {mag2_reg, 15'd0} - {15'd0, mag2_reg};
        m16_next  = prod16[45:31];
        m32_next  = (mag2_reg == '0) ? '0 : mag2_reg - 1'b1;
        lead_next = 5'd0;
        for (int b = 0; b < MAG_W; b++) begin
            if (mag2_reg[b]) begin
                lead_next = 5'(b);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld3) begin
            mag3_reg  <= mag2_reg;
            m16_reg   <= m16_next;
            m32_reg   <= m32_next;
            lead3_reg <= lead_next;
            neg3_reg  <= neg2_reg;
            eop3_reg  <= eop2_reg;
        end
    end

    // Stage 4 logic: normalise, round to nearest even, pack single, pick word by format
    always_comb begin
        norm       = mag3_reg << (5'd30 - lead3_reg);
        mant24     = norm[30:7];
        round_bits = norm[6:0];
        round_up   = (round_bits > 7'h40) || ((round_bits == 7'h40) && mant24[0]);
        mant_r     = {1'b0, mant24} + 25'(round_up);
        expo       = 8'(lead3_reg) + 8'd96 + 8'(mant_r[24]);
        frac       = mant_r[24] ? mant_r[23:1] : mant_r[22:0];
        float_word = (mag3_reg == '0) ? 32'd0 : {neg3_reg, expo, frac};
        pcm16_ext  = {17'd0, m16_reg};
        pcm32_ext  = {1'b0, m32_reg};
        case (cfg.sample_format)
            FMT_PCM16:   word_next = neg3_reg ? 32'd0 - pcm16_ext : pcm16_ext;
            FMT_PCM32:   word_next = neg3_reg ? 32'd0 - pcm32_ext : pcm32_ext;
            FMT_FLOAT:   word_next = float_word;
            FMT_SILENCE: word_next = 32'd0;
            default:     word_next = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ld4) begin
            word4_reg <= word_next;
            eop4_reg  <= eop3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_word  = word4_reg;
    assign out_eop   = eop4_reg;

endmodule

>>> hdl/stg_emit.sv
module stg_emit #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  stg_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [31:0]   in_word,
    input  logic          in_eop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [31:0]   m_word,
    output logic [2:0]    m_chan,
    output logic          m_last,
    output logic          m_pend
);
    import stg_pkg::*;

    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

    logic             valid_reg, valid_next;
    logic [31:0]      word_reg, word_next;
    logic [CNT_W-1:0] chan_reg, chan_next;
    logic             last_reg, last_next;
    logic             eop_reg, eop_next;
    logic             pend_reg, pend_next;
    logic [CNT_W-1:0] n_chan;
    logic [CNT_W-1:0] last_chan;
    logic [CNT_W-1:0] chan_inc;
    logic             adv;

    // Channel count, saturated to what the block supports
    assign n_chan    = (cfg.channel_count > 4'(MAX_CHANNELS)) ?
                       CNT_W'(MAX_CHANNELS) : CNT_W'(cfg.channel_count);
    assign last_chan = n_chan - 1'b1;
    assign chan_inc  = chan_reg + 1'b1;

    // Output register moves when empty or when its transfer completes;
    // a new frame enters as the last sample of the previous one goes out
    assign adv      = !valid_reg || m_ready;
    assign in_ready = adv && (!valid_reg || last_reg);

    always_comb begin
        valid_next = valid_reg;
        word_next  = word_reg;
        chan_next  = chan_reg;
        last_next  = last_reg;
        eop_next   = eop_reg;
        pend_next  = pend_reg;
        if (adv) begin
            if (valid_reg && !last_reg) begin
                chan_next = chan_inc;
                last_next = (chan_inc == last_chan);
                pend_next = (chan_inc == last_chan) && eop_reg;
            end else if (in_valid) begin
                valid_next = 1'b1;
                word_next  = in_word;
                chan_next  = '0;
                last_next  = (last_chan == '0);
                eop_next   = in_eop;
                pend_next  = (last_chan == '0) && in_eop;
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
        chan_reg <= chan_next;
        last_reg <= last_next;
        eop_reg  <= eop_next;
        pend_reg <= pend_next;
    end

    assign m_valid = valid_reg;
    assign m_word  = word_reg;
    assign m_chan  = 3'(chan_reg);
    assign m_last  = last_reg;
    assign m_pend  = pend_reg;

endmodule

>>> hdl/sine_tone_generator.sv
// Sine tone generator: each transfer on the slave stream requests one audio
// frame. The block reads the sine of its phase from a quarter-wave table,
// scales it by the amplitude register and converts it to 16-bit PCM, 32-bit
// PCM or IEEE single (or zero for silence), then sends the sample once per
// channel on the master stream and advances the phase by phase_step. The single
// output register repeats the sample per channel, so a frame with N channels
// yields N transfers and a zero-channel frame yields none; the next frame
// enters that register as the last sample of the previous one goes out. The
// request is written into a four-entry queue at its transfer, then passes table
// read, scaling, two conversion stages and the output register before its
// first sample is offered. Registers may only be written while no frame is in
// flight.
module sine_tone_generator #(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10,
    parameter int MAX_CHANNELS    = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    // frame requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [0] end_of_packet, [7:1] zero
    // samples
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // [31:0] sample_word
    output logic        m_axis_tlast,    // last_of_frame
    output logic [3:0]  m_axis_tuser     // [2:0] channel_index, [3] packet_end
);
    import stg_pkg::*;

    localparam int ENTRY_W = TABLE_ADDR_BITS + 2;

    cfg_t                       cfg_reg;
    logic                       q_full;
    logic                       q_push;
    logic [TABLE_ADDR_BITS-1:0] f_idx;
    logic                       f_neg;
    logic                       f_eop;
    logic [ENTRY_W-1:0]         q_in;
    logic [ENTRY_W-1:0]         q_out;
    logic                       q_valid;
    logic                       q_ready;
    logic                       syn_valid;
    logic                       syn_ready;
    logic [31:0]                syn_word;
    logic                       syn_eop;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.phase_step    <= PHASE_STEP_RST;
            cfg_reg.amplitude     <= AMPLITUDE_RST;
            cfg_reg.sample_format <= SAMPLE_FORMAT_RST;
            cfg_reg.channel_count <= CHANNEL_COUNT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_PHASE_STEP:    cfg_reg.phase_step    <= cfg_wdata;
                REG_AMPLITUDE:     cfg_reg.amplitude     <= cfg_wdata[15:0];
                REG_SAMPLE_FORMAT: cfg_reg.sample_format <= fmt_t'(cfg_wdata[1:0]);
                REG_CHANNEL_COUNT: cfg_reg.channel_count <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    stg_front #(
        .PHASE_BITS     (PHASE_BITS),
        .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
    ) u_front (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cfg    (cfg_reg),
        .s_valid(s_axis_tvalid),
        .s_ready(s_axis_tready),
        .s_eop  (s_axis_tdata[0]),
        .q_full (q_full),
        .q_push (q_push),
        .q_idx  (f_idx),
        .q_neg  (f_neg),
        .q_eop  (f_eop)
    );

    assign q_in = {f_eop, f_neg, f_idx};

    stg_queue #(
        .DATA_W(ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data(q_in),
        .full     (q_full),
        .pop_valid(q_valid),
        .pop_ready(q_ready),
        .pop_data (q_out)
    );

    stg_synth #(
        .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
    ) u_synth (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_idx   (q_out[TABLE_ADDR_BITS-1:0]),
        .in_neg   (q_out[TABLE_ADDR_BITS]),
        .in_eop   (q_out[TABLE_ADDR_BITS+1]),
        .out_valid(syn_valid),
        .out_ready(syn_ready),
        .out_word (syn_word),
        .out_eop  (syn_eop)
    );

    stg_emit #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_emit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .in_valid(syn_valid),
        .in_ready(syn_ready),
        .in_word (syn_word),
        .in_eop  (syn_eop),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_word  (m_axis_tdata),
        .m_chan  (m_axis_tuser[2:0]),
        .m_last  (m_axis_tlast),
        .m_pend  (m_axis_tuser[3])
    );

endmodule

>>> hdl/stg_checker.sv
module stg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [3:0]  m_axis_tuser
);

    logic out_xfer;

    assign out_xfer = m_axis_tvalid && m_axis_tready;

    // Nothing offered straight after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("sample offered after reset");

    // Stalled sample holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled sample changed");

    // Within a frame the same sample follows on the next channel at once
    a_next_chan: assert property (@(posedge aclk) disable iff (!aresetn)
        out_xfer && !m_axis_tlast |=>
            m_axis_tvalid && (m_axis_tuser[2:0] == $past(m_axis_tuser[2:0]) + 3'd1)
            && (m_axis_tdata == $past(m_axis_tdata)))
        else $error("channel sequence broken within frame");

    // A new frame starts on channel zero
    a_first_chan: assert property (@(posedge aclk) disable iff (!aresetn)
        out_xfer && m_axis_tlast |=> !m_axis_tvalid || (m_axis_tuser[2:0] == 3'd0))
        else $error("frame did not start on channel zero");

    // Packet end only on the last sample of a frame
    a_pend_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tlast)
        else $error("packet end outside frame end");

endmodule

bind sine_tone_generator stg_checker u_stg_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
);

>>> tb/tb_sine_tone_generator.sv
module tb_sine_tone_generator;
    import stg_pkg::*;

    // One sample as it should appear on the master stream
    typedef struct {
        logic [31:0] word;
        logic [2:0]  chan;
        logic        last;
        logic        pkt_end;
    } sample_t;

    localparam longint unsigned PI_FIXED = 64'd3373259426;   // pi in Q30
    localparam int              TBL_BITS = 10;
    localparam int              MAX_CH   = 8;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [1:0]  cfg_addr      = '0;
    logic [31:0] cfg_wdata     = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;    // [0] end_of_packet, [7:1] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [31:0] sample_word
    logic        m_axis_tlast;          // last_of_frame
    logic [3:0]  m_axis_tuser;          // [2:0] channel_index, [3] packet_end

    // Local copy of the oscillator state and its registers
    logic [31:0] osc_phase;
    logic [31:0] osc_step;
    logic [15:0] osc_amp;
    fmt_t        osc_fmt;
    logic [3:0]  osc_chans;
    logic [14:0] sine_rom [0:(1<<TBL_BITS)-1];

    bit      frame_requests [$];
    sample_t pending_samples [$];
    int      tx_idle_pct = 0;
    int      rx_idle_pct = 0;
    int      rx_hold     = 0;
    int      mismatches  = 0;

    sine_tone_generator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 aclk = ~aclk;

    // Quarter-wave entry: Taylor series of sin to x^13 in Q30 at the cell centre
    function automatic logic [14:0] sine_cell(int unsigned i);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned r;
        longint          acc;
        x    = (PI_FIXED * (2 * longint'(i) + 1)) >> (TBL_BITS + 2);
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int k = 1; k <= 6; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        r = (longint'(acc) * 32768 + (64'd1 << 29)) >> 30;
        if (r > 32767) begin
            r = 32767;
        end
        return r[14:0];
    endfunction

    // Q31 magnitude to IEEE single, round to nearest even
    function automatic logic [31:0] q31_to_single(bit neg, longint unsigned mag);
        int              msb;
        int              sh;
        longint unsigned mant;
        longint unsigned rem;
        longint unsigned half;
        logic [7:0]      expo;
        if (mag == 0) begin
            return 32'd0;
        end
        msb = 30;
        while (msb > 0 && mag[msb] == 1'b0) begin
            msb--;
        end
        expo = 8'(msb + 96);
        if (msb <= 23) begin
            mant = mag << (23 - msb);
        end else begin
            sh   = msb - 23;
            rem  = mag & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            mant = mag >> sh;
            if (rem > half || (rem == half && mant[0])) begin
                mant++;
            end
            if (mant >> 24) begin
                mant = mant >> 1;
                expo++;
            end
        end
        return {neg, expo, mant[22:0]};
    endfunction

    // Expected samples of one frame, then phase advance
    task automatic synth_frame_samples(bit eop);
        logic [1:0]      quad;
        logic [9:0]      idx;
        longint unsigned mag;
        longint unsigned m;
        logic [31:0]     word;
        int              n;
        sample_t         s;
        quad = osc_phase[31:30];
        idx  = osc_phase[29:20];
        if (quad[0]) begin
            idx = 10'h3FF - idx;
        end
        mag  = longint'(sine_rom[idx]) * longint'(osc_amp);
        word = '0;
        case (osc_fmt)
            FMT_PCM16: begin
                m    = (mag * 32767) >> 31;
                word = quad[1] ? 32'(0 - m[31:0]) : m[31:0];
            end
            FMT_PCM32: begin
                m    = (mag * 64'd2147483647) >> 31;
                word = quad[1] ? 32'(0 - m[31:0]) : m[31:0];
            end
            FMT_FLOAT: word = q31_to_single(quad[1], mag);
            default:   word = '0;
        endcase
        n = (osc_chans > MAX_CH) ? MAX_CH : int'(osc_chans);
        for (int c = 0; c < n; c++) begin
            s.word    = word;
            s.chan    = 3'(c);
            s.last    = (c + 1 == n);
            s.pkt_end = (c + 1 == n) ? eop : 1'b0;
            pending_samples.push_back(s);
        end
        osc_phase = osc_phase + osc_step;
    endtask

    // Request driver: holds tvalid until the transfer completes
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                synth_frame_samples(s_axis_tdata[0]);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (frame_requests.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'd0, frame_requests.pop_front()};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sample monitor and back-pressure
    always @(posedge aclk) begin : sample_mon
        sample_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_samples.size() == 0) begin
                    $error("unexpected sample transfer: word %h", m_axis_tdata);
                    mismatches++;
                end else begin
                    want = pending_samples.pop_front();
                    if (m_axis_tdata !== want.word) begin
                        $error("sample_word: expected %h, got %h", want.word, m_axis_tdata);
                        mismatches++;
                    end
                    if (m_axis_tuser[2:0] !== want.chan) begin
                        $error("channel_index: expected %0d, got %0d",
                               want.chan, m_axis_tuser[2:0]);
                        mismatches++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last_of_frame: expected %b, got %b", want.last, m_axis_tlast);
                        mismatches++;
                    end
                    if (m_axis_tuser[3] !== want.pkt_end) begin
                        $error("packet_end: expected %b, got %b",
                               want.pkt_end, m_axis_tuser[3]);
                        mismatches++;
                    end
                end
            end
            if (rx_hold > 0) begin
                rx_hold       <= rx_hold - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
    endtask

    // All four registers in a row, local copy kept in step
    task automatic load_config(logic [31:0] step, logic [15:0] amp, fmt_t fmt,
                               logic [3:0] chans);
        write_reg(REG_PHASE_STEP, step);
        write_reg(REG_AMPLITUDE, {16'd0, amp});
        write_reg(REG_SAMPLE_FORMAT, {30'd0, fmt});
        write_reg(REG_CHANNEL_COUNT, {28'd0, chans});
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        osc_step  = step;
        osc_amp   = amp;
        osc_fmt   = fmt;
        osc_chans = chans;
    endtask

    // Wait for the block to drain; zero-channel frames leave no trace, so pad
    task automatic wait_drained();
        while (frame_requests.size() > 0 || s_axis_tvalid || pending_samples.size() > 0) begin
            @(posedge aclk);
        end
        repeat (30) @(posedge aclk);
    endtask

    task automatic send_frames(int count, bit rand_eop);
        for (int i = 0; i < count; i++) begin
            frame_requests.push_back(rand_eop ? bit'($urandom_range(1)) : bit'(i % 2));
        end
        wait_drained();
    endtask

    initial begin
        logic [31:0] step;
        logic [15:0] amp;
        logic [3:0]  chans;
        for (int i = 0; i < (1 << TBL_BITS); i++) begin
            sine_rom[i] = sine_cell(i);
        end
        osc_phase = '0;
        osc_step  = PHASE_STEP_RST;
        osc_amp   = AMPLITUDE_RST;
        osc_fmt   = SAMPLE_FORMAT_RST;
        osc_chans = CHANNEL_COUNT_RST;
        tx_idle_pct = 10;
        rx_idle_pct = 71;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset settings, quadrants, extremes, zero and excess channels
        send_frames(2, 1'b0);
        load_config(32'h4000_0000, 16'hFFFF, FMT_PCM16, 4'd1);
        send_frames(4, 1'b0);
        load_config(32'hFFFF_FFFF, 16'hFFFF, FMT_PCM32, 4'd8);
        send_frames(3, 1'b0);
        load_config(32'h0123_4567, 16'd1, FMT_FLOAT, 4'd0);
        send_frames(2, 1'b0);
        load_config(32'h1000_0000, 16'h8000, FMT_FLOAT, 4'd15);
        send_frames(2, 1'b0);
        load_config(32'h0000_0000, 16'd0, FMT_SILENCE, 4'd9);
        send_frames(2, 1'b0);
        load_config(32'h0008_0000, 16'd0, FMT_FLOAT, 4'd3);
        send_frames(2, 1'b0);
        load_config(32'h0010_0000, 16'hFFFF, FMT_PCM16, 4'd2);
        send_frames(4, 1'b0);

        // Random phases, each under a fresh setting
        for (int p = 0; p < 8; p++) begin
            if (p < 3) begin
                tx_idle_pct = 10;
                rx_idle_pct = 71;
            end else if (p < 6) begin
                tx_idle_pct = 71;
                rx_idle_pct = 10;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case ($urandom_range(7))
                0:       step = 32'h0000_0000;
                1:       step = 32'hFFFF_FFFF;
                2:       step = 32'h8000_0000;
                default: step = $urandom;
            endcase
            case ($urandom_range(3))
                0:       amp = $urandom_range(1) ? 16'hFFFF : 16'd0;
                default: amp = 16'($urandom);
            endcase
            case ($urandom_range(9))
                0:       chans = 4'd0;
                1:       chans = 4'($urandom_range(15, 9));
                default: chans = 4'($urandom_range(8, 1));
            endcase
            // long receiver hold-off with full frames, so the request queue backs up
            if (p == 3) begin
                chans = 4'd8;
            end
            load_config(step, amp, fmt_t'($urandom_range(3)), chans);
            if (p == 3) begin
                @(posedge aclk);
                rx_hold <= 400;
            end
            send_frames(14, 1'b1);
        end

        if (mismatches == 0) begin
            $display("tb_sine_tone_generator: clean");
        end else begin
            $display("tb_sine_tone_generator: errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("tb_sine_tone_generator: errors");
        $finish;
    end

endmodule

>>> filelist.f
hdl/stg_pkg.sv
hdl/stg_front.sv
hdl/stg_queue.sv
hdl/stg_synth.sv
hdl/stg_emit.sv
hdl/sine_tone_generator.sv
hdl/stg_checker.sv
tb/tb_sine_tone_generator.sv
